>>> design/xcr_pkg.sv
// ============================================================================
// XMODEM-CRC receiver package
// Shared types, protocol codes and register reset values for the receiver.
// ============================================================================
`default_nettype none

package xcr_pkg;

    // Depth of the result queue between the protocol engine and the output.
    localparam int XCR_QUEUE_DEPTH = 8;

    // Widths of the fields of a request and of a result.
    localparam int ACTION_W = 2;
    localparam int BYTE_W   = 8;
    localparam int LEN_W    = 24;
    localparam int TICK_W   = 32;
    localparam int RETRY_W  = 8;
    localparam int KIND_W   = 2;
    localparam int STATUS_W = 3;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 32;

    // Input actions.
    localparam logic [ACTION_W-1:0] ACT_BYTE  = 2'd0;
    localparam logic [ACTION_W-1:0] ACT_TICK  = 2'd1;
    localparam logic [ACTION_W-1:0] ACT_START = 2'd2;

    // Result kinds.
    localparam logic [KIND_W-1:0] KIND_TX    = 2'd0;
    localparam logic [KIND_W-1:0] KIND_WRITE = 2'd1;
    localparam logic [KIND_W-1:0] KIND_DONE  = 2'd2;

    // Completion status codes.
    localparam logic [STATUS_W-1:0] ST_OK       = 3'd0;
    localparam logic [STATUS_W-1:0] ST_TIMEOUT  = 3'd1;
    localparam logic [STATUS_W-1:0] ST_PROTOCOL = 3'd2;
    localparam logic [STATUS_W-1:0] ST_CANCEL   = 3'd3;
    localparam logic [STATUS_W-1:0] ST_OVERFLOW = 3'd4;

    // Protocol characters.
    localparam logic [BYTE_W-1:0] CHR_SOH = 8'h01;
    localparam logic [BYTE_W-1:0] CHR_EOT = 8'h04;
    localparam logic [BYTE_W-1:0] CHR_ACK = 8'h06;
    localparam logic [BYTE_W-1:0] CHR_NAK = 8'h15;
    localparam logic [BYTE_W-1:0] CHR_CAN = 8'h18;
    localparam logic [BYTE_W-1:0] CHR_C   = 8'h43;

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] CFG_MAX_LENGTH = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_TICK_LIMIT = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_RETRY_LIMIT = 2'd2;

    // Register reset values.
    localparam logic [LEN_W-1:0]   RST_MAX_LENGTH  = 24'hFF_FFFF;
    localparam logic [TICK_W-1:0]  RST_TICK_LIMIT  = 32'd27000000;
    localparam logic [RETRY_W-1:0] RST_RETRY_LIMIT = 8'd16;

    // Protocol phase.
    typedef enum logic [3:0] {
        PH_IDLE,
        PH_HEAD,
        PH_CAN2,
        PH_NUM,
        PH_INV,
        PH_DATA,
        PH_CRCHI,
        PH_CRCLO
    } t_phase;

    // Live configuration handed to the protocol engine.
    typedef struct packed {
        logic [LEN_W-1:0]   max_length;
        logic [TICK_W-1:0]  tick_limit;
        logic [RETRY_W-1:0] retry_limit;
    } t_cfg;

    // One result item.
    typedef struct packed {
        logic [KIND_W-1:0]   kind;
        logic [BYTE_W-1:0]   value;
        logic [LEN_W-1:0]    write_offset;
        logic [LEN_W-1:0]    committed_length;
        logic [STATUS_W-1:0] status;
        logic                last;
    } t_result;

    // Results produced by one request, pushed into the queue together.
    typedef struct packed {
        logic [1:0]        cnt;
        t_result [2:0]     items;
    } t_push;

    // Builds a result item; the last flag is set once the count is known.
    function automatic t_result xcr_result(
        input logic [KIND_W-1:0]   kind,
        input logic [BYTE_W-1:0]   value,
        input logic [LEN_W-1:0]    offset,
        input logic [LEN_W-1:0]    committed,
        input logic [STATUS_W-1:0] status
    );
        t_result r;
        r.kind             = kind;
        r.value            = value;
        r.write_offset     = offset;
        r.committed_length = committed;
        r.status           = status;
        r.last             = 1'b0;
        return r;
    endfunction

endpackage

`default_nettype wire

>>> design/xcr_if.sv
// ============================================================================
// XMODEM-CRC receiver channels
// Valid/ready channels for requests, results and configuration writes.
// ============================================================================
`default_nettype none

// Request channel: one received byte, timer tick or start command.
interface xcr_in_if;
    import xcr_pkg::*;
    logic                valid;
    logic                ready;
    logic [ACTION_W-1:0] action;
    logic [BYTE_W-1:0]   rx_byte;

    modport source (output valid, output action, output rx_byte, input ready);
    modport sink   (input valid, input action, input rx_byte, output ready);
endinterface

// Result channel: transmit byte, staged payload write or completion.
interface xcr_out_if;
    import xcr_pkg::*;
    logic                valid;
    logic                ready;
    logic [KIND_W-1:0]   kind;
    logic [BYTE_W-1:0]   value;
    logic [LEN_W-1:0]    write_offset;
    logic [LEN_W-1:0]    committed_length;
    logic [STATUS_W-1:0] status;
    logic                last;

    modport source (output valid, output kind, output value, output write_offset,
                    output committed_length, output status, output last,
                    input ready);
    modport sink   (input valid, input kind, input value, input write_offset,
                    input committed_length, input status, input last,
                    output ready);
endinterface

// Configuration write channel.
interface xcr_cfg_if;
    import xcr_pkg::*;
    logic                  valid;
    logic                  ready;
    logic [CFG_IDX_W-1:0]  index;
    logic [CFG_DATA_W-1:0] data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

`default_nettype wire

>>> design/xmodem_crc_receiver.sv
// ============================================================================
// XMODEM-CRC receiver
// Top level: configuration registers, protocol engine and result queue.
// ============================================================================
// A request (received byte, timer tick or start) is accepted in any cycle in
// which the result queue has room for three results beyond those of the
// request already being decoded, so one request per cycle is taken while
// results drain. Each request is registered, decoded against the protocol
// state, and its zero to three results are written into the result queue,
// from whose storage the first of them is offered. The result channel
// delivers one result per cycle while the consumer is ready, so the sustained
// request rate equals one per cycle while requests average at most one result
// each, and otherwise is set by the queue draining at one result per cycle.
// Configuration writes are always accepted and take effect on the next request.
`default_nettype none

module xmodem_crc_receiver #(
    parameter int QUEUE_DEPTH = xcr_pkg::XCR_QUEUE_DEPTH
) (
    input  logic   i_clk,
    input  logic   i_rst_n,
    xcr_in_if.sink i_in,
    xcr_cfg_if.sink i_cfg,
    xcr_out_if.source o_out
);
    import xcr_pkg::*;

    logic [LEN_W-1:0]   r_max_length;
    logic [TICK_W-1:0]  r_tick_limit;
    logic [RETRY_W-1:0] r_retry_limit;
    t_cfg               cfg;
    t_push              push;
    logic               room;

    assign i_cfg.ready = 1'b1;

    // Configuration registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_max_length  <= RST_MAX_LENGTH;
            r_tick_limit  <= RST_TICK_LIMIT;
            r_retry_limit <= RST_RETRY_LIMIT;
        end else if (i_cfg.valid && i_cfg.ready) begin
            unique case (i_cfg.index)
                CFG_MAX_LENGTH:  r_max_length  <= i_cfg.data[LEN_W-1:0];
                CFG_TICK_LIMIT:  r_tick_limit  <= i_cfg.data[TICK_W-1:0];
                CFG_RETRY_LIMIT: r_retry_limit <= i_cfg.data[RETRY_W-1:0];
                default: r_retry_limit <= r_retry_limit;
            endcase
        end
    end

    assign cfg.max_length  = r_max_length;
    assign cfg.tick_limit  = r_tick_limit;
    assign cfg.retry_limit = r_retry_limit;

    // Protocol engine.
    xcr_core u_core (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (i_in),
        .i_cfg   (cfg),
        .i_room  (room),
        .o_push  (push)
    );

    // Result queue.
    xcr_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .o_room  (room),
        .o_out   (o_out)
    );

endmodule

`default_nettype wire

>>> design/xcr_core.sv
// ============================================================================
// XMODEM-CRC protocol engine
// Registers each request, decodes it against the protocol state in one pass
// and produces the state update and up to three results for the queue.
// ============================================================================
`default_nettype none

module xcr_core (
    input  logic           i_clk,
    input  logic           i_rst_n,
    xcr_in_if.sink         i_in,
    input  xcr_pkg::t_cfg  i_cfg,
    input  logic           i_room,
    output xcr_pkg::t_push o_push
);
    import xcr_pkg::*;

    // Outcome of one request.
    typedef enum logic [3:0] {
        EV_NONE,
        EV_START,
        EV_TICK,
        EV_HEAD,
        EV_FAIL,
        EV_EOT,
        EV_CANCEL,
        EV_CAN1,
        EV_SOH,
        EV_NUM,
        EV_INV,
        EV_DATA,
        EV_CRCHI,
        EV_ACK,
        EV_OVERFLOW
    } t_event;

    typedef struct packed {
        t_event              ev;
        logic [STATUS_W-1:0] st;
        logic                nak;
    } t_decision;

    localparam logic [6:0]       LAST_INDEX = 7'd127;
    localparam logic [LEN_W:0]   BLOCK_LEN  = 25'd128;
    localparam logic [15:0]      CRC_POLY   = 16'h1021;

    // One byte of the CRC-16 update, most significant bit first.
    function automatic logic [15:0] crc_byte(input logic [15:0] crc,
                                             input logic [7:0] b);
        logic [15:0] c;
        c = crc ^ {b, 8'h00};
        for (int i = 0; i < 8; i++) begin
            c = c[15] ? ((c << 1) ^ CRC_POLY) : (c << 1);
        end
        return c;
    endfunction

    // Input register.
    logic                r_in_valid;
    logic [ACTION_W-1:0] r_action;
    logic [BYTE_W-1:0]   r_byte;

    // Protocol state.
    t_phase              r_phase,   n_phase;
    logic                r_started, n_started;
    logic [RETRY_W-1:0]  r_retry,   n_retry;
    logic [BYTE_W-1:0]   r_expect,  n_expect;
    logic [LEN_W-1:0]    r_acc,     n_acc;
    logic [BYTE_W-1:0]   r_blk,     n_blk;
    logic [BYTE_W-1:0]   r_inv,     n_inv;
    logic [6:0]          r_pidx,    n_pidx;
    logic [15:0]         r_crc,     n_crc;
    logic [BYTE_W-1:0]   r_crc_hi,  n_crc_hi;
    logic [TICK_W-1:0]   r_wait,    n_wait;

    logic                accept;
    t_decision           dec;
    logic [TICK_W-1:0]   wait_inc;
    logic                timed_out;
    logic [RETRY_W-1:0]  retry_inc;
    logic                abort;
    logic                fits;
    logic                is_expected;
    logic                block_ok;
    logic [LEN_W-1:0]    acc_next_block;

    assign i_in.ready = i_room;
    assign accept     = i_in.valid && i_room;

    // Capture the request; it is always consumed in the following cycle.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else begin
            r_in_valid <= accept;
        end
        if (accept) begin
            r_action <= i_in.action;
            r_byte   <= i_in.rx_byte;
        end
    end

    // Shared conditions.
    assign wait_inc       = (r_wait == '1) ? r_wait : r_wait + TICK_W'(1);
    assign timed_out      = wait_inc > i_cfg.tick_limit;
    assign retry_inc      = (r_retry == '1) ? r_retry : r_retry + RETRY_W'(1);
    assign abort          = retry_inc >= i_cfg.retry_limit;
    assign fits           = ({1'b0, r_acc} + BLOCK_LEN) <= {1'b0, i_cfg.max_length};
    assign is_expected    = r_blk == r_expect;
    assign block_ok       = (BYTE_W'(r_blk + r_inv) == 8'hFF) && (r_crc == {r_crc_hi, r_byte});
    assign acc_next_block = r_acc + BLOCK_LEN[LEN_W-1:0];

    // Decode the registered request against the current phase.
    always_comb begin
        dec.ev  = EV_NONE;
        dec.st  = ST_OK;
        dec.nak = 1'b0;
        if (r_in_valid) begin
            unique case (r_action)
                ACT_START: begin
                    dec.ev = EV_START;
                end
                ACT_TICK: begin
                    if (r_phase != PH_IDLE) begin
                        if (!timed_out) begin
                            dec.ev = EV_TICK;
                        end else if (r_phase == PH_HEAD) begin
                            dec.ev = EV_FAIL;
                            dec.st = ST_TIMEOUT;
                        end else if (r_phase == PH_CAN2) begin
                            dec.ev = EV_HEAD;
                        end else begin
                            dec.ev  = EV_FAIL;
                            dec.st  = ST_TIMEOUT;
                            dec.nak = 1'b1;
                        end
                    end
                end
                ACT_BYTE: begin
                    unique case (r_phase)
                        PH_HEAD: begin
                            if (r_byte == CHR_EOT) begin
                                dec.ev = EV_EOT;
                            end else if (r_byte == CHR_CAN) begin
                                dec.ev = EV_CAN1;
                            end else if (r_byte == CHR_SOH) begin
                                dec.ev = EV_SOH;
                            end else begin
                                dec.ev = EV_FAIL;
                                dec.st = ST_PROTOCOL;
                            end
                        end
                        PH_CAN2: begin
                            dec.ev = (r_byte == CHR_CAN) ? EV_CANCEL : EV_HEAD;
                        end
                        PH_NUM:   dec.ev = EV_NUM;
                        PH_INV:   dec.ev = EV_INV;
                        PH_DATA:  dec.ev = EV_DATA;
                        PH_CRCHI: dec.ev = EV_CRCHI;
                        PH_CRCLO: begin
                            if (!block_ok) begin
                                dec.ev  = EV_FAIL;
                                dec.st  = ST_PROTOCOL;
                                dec.nak = 1'b1;
                            end else if (is_expected) begin
                                dec.ev = fits ? EV_ACK : EV_OVERFLOW;
                            end else if (r_blk != BYTE_W'(r_expect - 8'd1)) begin
                                dec.ev  = EV_FAIL;
                                dec.st  = ST_PROTOCOL;
                                dec.nak = 1'b1;
                            end else begin
                                dec.ev = EV_ACK;
                            end
                        end
                        default: dec.ev = EV_NONE;
                    endcase
                end
                default: dec.ev = EV_NONE;
            endcase
        end
    end

    // Next protocol state.
    always_comb begin
        n_phase   = r_phase;
        n_started = r_started;
        n_retry   = r_retry;
        n_expect  = r_expect;
        n_acc     = r_acc;
        n_blk     = r_blk;
        n_inv     = r_inv;
        n_pidx    = r_pidx;
        n_crc     = r_crc;
        n_crc_hi  = r_crc_hi;
        n_wait    = r_wait;
        unique case (dec.ev)
            EV_NONE: begin
                n_wait = r_wait;
            end
            EV_START: begin
                n_started = 1'b0;
                n_retry   = '0;
                n_expect  = 8'd1;
                n_acc     = '0;
                n_pidx    = '0;
                n_crc     = '0;
                n_phase   = PH_HEAD;
                n_wait    = '0;
            end
            EV_TICK: begin
                n_wait = wait_inc;
            end
            EV_HEAD: begin
                n_phase = PH_HEAD;
                n_wait  = '0;
            end
            EV_FAIL: begin
                n_retry = retry_inc;
                n_phase = abort ? PH_IDLE : PH_HEAD;
                n_wait  = '0;
            end
            EV_EOT, EV_CANCEL, EV_OVERFLOW: begin
                n_phase = PH_IDLE;
                n_wait  = '0;
            end
            EV_CAN1: begin
                n_phase = PH_CAN2;
                n_wait  = '0;
            end
            EV_SOH: begin
                n_started = 1'b1;
                n_phase   = PH_NUM;
                n_wait    = '0;
            end
            EV_NUM: begin
                n_blk   = r_byte;
                n_phase = PH_INV;
                n_wait  = '0;
            end
            EV_INV: begin
                n_inv   = r_byte;
                n_pidx  = '0;
                n_crc   = '0;
                n_phase = PH_DATA;
                n_wait  = '0;
            end
            EV_DATA: begin
                n_crc  = crc_byte(r_crc, r_byte);
                n_wait = '0;
                if (r_pidx == LAST_INDEX) begin
                    n_pidx  = '0;
                    n_phase = PH_CRCHI;
                end else begin
                    n_pidx = r_pidx + 7'd1;
                end
            end
            EV_CRCHI: begin
                n_crc_hi = r_byte;
                n_phase  = PH_CRCLO;
                n_wait   = '0;
            end
            EV_ACK: begin
                if (is_expected) begin
                    n_acc    = acc_next_block;
                    n_expect = r_expect + 8'd1;
                end
                n_retry = '0;
                n_phase = PH_HEAD;
                n_wait  = '0;
            end
            default: n_phase = r_phase;
        endcase
    end

    // Results of the request, in the order they go out.
    always_comb begin
        logic [1:0]    cnt;
        t_result [2:0] items;
        cnt   = '0;
        items = '0;
        unique case (dec.ev)
            EV_START: begin
                items[cnt] = xcr_result(KIND_TX, CHR_C, '0, '0, ST_OK);
                cnt        = cnt + 2'd1;
            end
            EV_HEAD: begin
                if (!r_started) begin
                    items[cnt] = xcr_result(KIND_TX, CHR_C, '0, r_acc, ST_OK);
                    cnt        = cnt + 2'd1;
                end
            end
            EV_FAIL: begin
                if (dec.nak) begin
                    items[cnt] = xcr_result(KIND_TX, CHR_NAK, '0, r_acc, ST_OK);
                    cnt        = cnt + 2'd1;
                end
                if (abort) begin
                    items[cnt] = xcr_result(KIND_DONE, '0, '0, r_acc, dec.st);
                    cnt        = cnt + 2'd1;
                end else if (!r_started) begin
                    items[cnt] = xcr_result(KIND_TX, CHR_C, '0, r_acc, ST_OK);
                    cnt        = cnt + 2'd1;
                end
            end
            EV_EOT: begin
                items[0] = xcr_result(KIND_TX, CHR_ACK, '0, r_acc, ST_OK);
                items[1] = xcr_result(KIND_DONE, '0, '0, r_acc, ST_OK);
                cnt      = 2'd2;
            end
            EV_CANCEL: begin
                items[0] = xcr_result(KIND_DONE, '0, '0, r_acc, ST_CANCEL);
                cnt      = 2'd1;
            end
            EV_DATA: begin
                if (is_expected && fits) begin
                    items[0] = xcr_result(KIND_WRITE, r_byte, r_acc + LEN_W'(r_pidx),
                                          r_acc, ST_OK);
                    cnt      = 2'd1;
                end
            end
            EV_OVERFLOW: begin
                items[0] = xcr_result(KIND_TX, CHR_CAN, '0, r_acc, ST_OK);
                items[1] = xcr_result(KIND_TX, CHR_CAN, '0, r_acc, ST_OK);
                items[2] = xcr_result(KIND_DONE, '0, '0, r_acc, ST_OVERFLOW);
                cnt      = 2'd3;
            end
            EV_ACK: begin
                items[cnt] = xcr_result(KIND_TX, CHR_ACK, '0, n_acc, ST_OK);
                cnt        = cnt + 2'd1;
                if (!r_started) begin
                    items[cnt] = xcr_result(KIND_TX, CHR_C, '0, n_acc, ST_OK);
                    cnt        = cnt + 2'd1;
                end
            end
            default: cnt = '0;
        endcase
        // Mark the final result of this request.
        if (cnt != 2'd0) begin
            items[cnt - 2'd1].last = 1'b1;
        end
        o_push.cnt   = cnt;
        o_push.items = items;
    end

    // Protocol state registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase   <= PH_IDLE;
            r_started <= 1'b0;
            r_retry   <= '0;
            r_expect  <= 8'd1;
            r_acc     <= '0;
            r_pidx    <= '0;
            r_crc     <= '0;
            r_wait    <= '0;
        end else begin
            r_phase   <= n_phase;
            r_started <= n_started;
            r_retry   <= n_retry;
            r_expect  <= n_expect;
            r_acc     <= n_acc;
            r_pidx    <= n_pidx;
            r_crc     <= n_crc;
            r_wait    <= n_wait;
        end
        r_blk    <= n_blk;
        r_inv    <= n_inv;
        r_crc_hi <= n_crc_hi;
    end

endmodule

`default_nettype wire

>>> design/xcr_queue.sv
// ============================================================================
// XMODEM-CRC result queue
// Takes up to three results per cycle from the engine and hands them out one
// at a time on the result channel.
// ============================================================================
`default_nettype none

module xcr_queue #(
    parameter int DEPTH = xcr_pkg::XCR_QUEUE_DEPTH
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  xcr_pkg::t_push i_push,
    output logic           o_room,
    xcr_out_if.source      o_out
);
    import xcr_pkg::*;

    localparam int AW = $clog2(DEPTH);
    localparam int CW = $clog2(DEPTH + 1);

    // Pointer increment with wrap at any depth.
    function automatic logic [AW-1:0] wrap_add(input logic [AW-1:0] a,
                                               input logic [1:0] k);
        logic [AW:0] s;
        s = {1'b0, a} + (AW+1)'(k);
        if (s >= (AW+1)'(DEPTH)) begin
            s = s - (AW+1)'(DEPTH);
        end
        return s[AW-1:0];
    endfunction

    t_result         r_mem [DEPTH];
    logic [AW-1:0]   r_wr;
    logic [AW-1:0]   r_rd;
    logic [CW-1:0]   r_count;
    logic            pop;
    logic [CW:0]     free;
    t_result         head;

    assign pop  = o_out.valid && o_out.ready;
    assign free = (CW+1)'(DEPTH) - {1'b0, r_count};

    // Room for a new request once the pending push has landed.
    assign o_room = free >= ((CW+1)'(i_push.cnt) + (CW+1)'(3));

    // Output side.
    assign head                   = r_mem[r_rd];
    assign o_out.valid            = r_count != '0;
    assign o_out.kind             = head.kind;
    assign o_out.value            = head.value;
    assign o_out.write_offset     = head.write_offset;
    assign o_out.committed_length = head.committed_length;
    assign o_out.status           = head.status;
    assign o_out.last             = head.last;

    // Storage writes.
    always_ff @(posedge i_clk) begin
        for (int i = 0; i < 3; i++) begin
            if (2'(i) < i_push.cnt) begin
                r_mem[wrap_add(r_wr, 2'(i))] <= i_push.items[i];
            end
        end
    end

    // Pointers and fill count.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr    <= '0;
            r_rd    <= '0;
            r_count <= '0;
        end else begin
            r_wr    <= wrap_add(r_wr, i_push.cnt);
            if (pop) begin
                r_rd <= wrap_add(r_rd, 2'd1);
            end
            r_count <= CW'({1'b0, r_count} + (CW+1)'(i_push.cnt) - (CW+1)'(pop));
        end
    end

`ifndef SYNTHESIS
    // The engine only pushes what the queue can hold.
    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (CW+1)'(i_push.cnt) <= free)
        else $error("result queue overflow");

    // The fill count never passes the depth.
    a_count_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        {1'b0, r_count} <= (CW+1)'(DEPTH))
        else $error("result queue count out of range");

    // A pushed result is offered on the following cycle.
    a_push_shows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_push.cnt != 2'd0) |=> o_out.valid)
        else $error("pushed result not offered");
`endif

endmodule

`default_nettype wire
